>>> rtl/core/srb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and codes for the serial ring buffers with line count.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int RING_DEPTH_DEF = 256;

    localparam int BYTE_W  = 8;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W = 2;

    // opcodes
    localparam logic [OP_W-1:0] OP_RECV     = 3'd0;
    localparam logic [OP_W-1:0] OP_POP      = 3'd1;
    localparam logic [OP_W-1:0] OP_PUSH     = 3'd2;
    localparam logic [OP_W-1:0] OP_TX_READY = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH    = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_CODE = 2'd1;

    localparam logic [BYTE_W-1:0] START_CODE_RST    = 8'd2;
    localparam logic [BYTE_W-1:0] LINE_END_CODE_RST = 8'd13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;  // latch input word, start ring reads
        logic exec;     // apply the word, load the result register
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/core/srb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ctrl
// Sequencer: accepts one word, runs it through the datapath, holds the result.
// ----------------------------------------------------------------------------
module srb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output srb_pkg::t_cmd      o_cmd
);

    srb_pkg::t_state r_state;
    srb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ready       = 1'b0;
        o_valid       = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            srb_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = srb_pkg::ST_EXEC;
                end
            end
            srb_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = srb_pkg::ST_OUT;
            end
            srb_pkg::ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = srb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/srb_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_dp
// Datapath: receive and transmit rings, pointers, fill counts, line count,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module srb_dp #(
    parameter int RING_DEPTH = srb_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [srb_pkg::BYTE_W-1:0]    i_cfg_data,
    input  wire srb_pkg::t_cmd                 i_cmd,
    input  wire logic [srb_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [srb_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_divert_mode,
    output logic [srb_pkg::BYTE_W-1:0]         o_popped_byte,
    output logic                               o_popped_valid,
    output logic                               o_empty_pop,
    output logic [srb_pkg::BYTE_W-1:0]         o_send_byte,
    output logic                               o_send_valid,
    output logic [srb_pkg::BYTE_W-1:0]         o_packet_byte,
    output logic                               o_packet_valid,
    output logic                               o_line_event,
    output logic                               o_bytes_waiting,
    output logic [srb_pkg::BYTE_W-1:0]         o_lines_waiting,
    output logic                               o_transmit_on,
    output logic                               o_push_dropped
);

    localparam int PTR_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int BW     = srb_pkg::BYTE_W;

    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(RING_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        nxt = (ptr == PTR_LAST) ? '0 : ptr + 1'b1;
        return nxt;
    endfunction

    logic [BW-1:0] rx_mem [RING_DEPTH];
    logic [BW-1:0] tx_mem [RING_DEPTH];

    logic [BW-1:0]         r_start_code, r_line_end_code;
    logic [srb_pkg::OP_W-1:0] r_op;
    logic [BW-1:0]         r_data;
    logic                  r_divert;
    logic [BW-1:0]         r_rx_q, r_tx_q;

    logic [PTR_W-1:0]  r_rx_wr, r_rx_rd, r_tx_wr, r_tx_sent;
    logic [PTR_W-1:0]  n_rx_wr, n_rx_rd, n_tx_wr, n_tx_sent;
    logic [FILL_W-1:0] r_rx_fill, r_tx_fill, n_rx_fill, n_tx_fill;
    logic [BW-1:0]     r_lines, n_lines;
    logic              r_drain, n_drain;

    logic          rx_we, tx_we;
    logic [BW-1:0] n_popped_byte, n_send_byte, n_packet_byte;
    logic          n_popped_valid, n_empty_pop, n_send_valid;
    logic          n_packet_valid, n_line_event, n_push_dropped;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code    <= srb_pkg::START_CODE_RST;
            r_line_end_code <= srb_pkg::LINE_END_CODE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == srb_pkg::CFG_START_CODE) begin
                r_start_code <= i_cfg_data;
            end else if (i_cfg_idx == srb_pkg::CFG_LINE_END_CODE) begin
                r_line_end_code <= i_cfg_data;
            end
        end
    end

    // input word and ring read ports; head data is ready by the exec cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_data   <= i_data_byte;
            r_divert <= i_divert_mode;
            r_rx_q   <= rx_mem[r_rx_rd];
            r_tx_q   <= tx_mem[r_tx_sent];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_we) begin
            rx_mem[r_rx_wr] <= r_data;
        end
        if (tx_we) begin
            tx_mem[r_tx_wr] <= r_data;
        end
    end

    always_comb begin
        n_rx_wr        = r_rx_wr;
        n_rx_rd        = r_rx_rd;
        n_tx_wr        = r_tx_wr;
        n_tx_sent      = r_tx_sent;
        n_rx_fill      = r_rx_fill;
        n_tx_fill      = r_tx_fill;
        n_lines        = r_lines;
        n_drain        = r_drain;
        rx_we          = 1'b0;
        tx_we          = 1'b0;
        n_popped_byte  = '0;
        n_popped_valid = 1'b0;
        n_empty_pop    = 1'b0;
        n_send_byte    = '0;
        n_send_valid   = 1'b0;
        n_packet_byte  = '0;
        n_packet_valid = 1'b0;
        n_line_event   = 1'b0;
        n_push_dropped = 1'b0;
        if (i_cmd.exec) begin
            unique case (r_op)
                srb_pkg::OP_RECV: begin
                    if (r_divert || (r_data == r_start_code)) begin
                        n_packet_byte  = r_data;
                        n_packet_valid = 1'b1;
                    end else if (r_rx_fill != FILL_FULL) begin
                        rx_we     = 1'b1;
                        n_rx_wr   = advance(r_rx_wr);
                        n_rx_fill = r_rx_fill + 1'b1;
                        if (r_data == r_line_end_code) begin
                            n_lines      = r_lines + 1'b1;
                            n_line_event = 1'b1;
                        end
                    end
                end
                srb_pkg::OP_POP: begin
                    if (r_rx_fill == '0) begin
                        n_empty_pop = 1'b1;
                    end else begin
                        n_rx_rd        = advance(r_rx_rd);
                        n_rx_fill      = r_rx_fill - 1'b1;
                        n_popped_byte  = r_rx_q;
                        n_popped_valid = 1'b1;
                        if (r_rx_q == r_line_end_code) begin
                            n_lines = r_lines - 1'b1;
                        end
                    end
                end
                srb_pkg::OP_PUSH: begin
                    if (r_tx_fill != FILL_FULL) begin
                        tx_we     = 1'b1;
                        n_tx_wr   = advance(r_tx_wr);
                        n_tx_fill = r_tx_fill + 1'b1;
                    end else begin
                        n_push_dropped = 1'b1;
                    end
                    // ring holds at least one byte either way
                    n_drain = 1'b1;
                end
                srb_pkg::OP_TX_READY: begin
                    if (r_drain) begin
                        if (r_tx_fill != '0) begin
                            n_send_byte  = r_tx_q;
                            n_send_valid = 1'b1;
                            n_tx_sent    = advance(r_tx_sent);
                            n_tx_fill    = r_tx_fill - 1'b1;
                        end else begin
                            n_drain = 1'b0;
                        end
                    end
                end
                srb_pkg::OP_FLUSH: begin
                    n_rx_wr   = '0;
                    n_rx_rd   = '0;
                    n_tx_wr   = '0;
                    n_tx_sent = '0;
                    n_rx_fill = '0;
                    n_tx_fill = '0;
                    n_lines   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr   <= '0;
            r_rx_rd   <= '0;
            r_tx_wr   <= '0;
            r_tx_sent <= '0;
            r_rx_fill <= '0;
            r_tx_fill <= '0;
            r_lines   <= '0;
            r_drain   <= 1'b0;
        end else begin
            r_rx_wr   <= n_rx_wr;
            r_rx_rd   <= n_rx_rd;
            r_tx_wr   <= n_tx_wr;
            r_tx_sent <= n_tx_sent;
            r_rx_fill <= n_rx_fill;
            r_tx_fill <= n_tx_fill;
            r_lines   <= n_lines;
            r_drain   <= n_drain;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_popped_byte   <= n_popped_byte;
            o_popped_valid  <= n_popped_valid;
            o_empty_pop     <= n_empty_pop;
            o_send_byte     <= n_send_byte;
            o_send_valid    <= n_send_valid;
            o_packet_byte   <= n_packet_byte;
            o_packet_valid  <= n_packet_valid;
            o_line_event    <= n_line_event;
            o_bytes_waiting <= (n_rx_fill != '0);
            o_lines_waiting <= n_lines;
            o_transmit_on   <= n_drain;
            o_push_dropped  <= n_push_dropped;
        end
    end

    a_rx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_fill <= FILL_FULL)
        else $error("receive fill count beyond ring depth");

    a_tx_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_fill <= FILL_FULL)
        else $error("transmit fill count beyond ring depth");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == srb_pkg::OP_FLUSH) |=>
            (r_rx_fill == '0 && r_tx_fill == '0 && r_lines == '0))
        else $error("flush left data in the rings");

    a_state_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> ($stable(r_rx_fill) && $stable(r_tx_fill) && $stable(r_drain)))
        else $error("ring state changed outside exec");

endmodule
`default_nettype wire

>>> rtl/core/serial_ring_buffers_line_count.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_ring_buffers_line_count
// Receive and transmit byte rings between a serial port and a host, with a
// count of complete lines held in the receive ring.
//
//   channel   direction  handshake          payload
//   cfg       in         i_cfg_we           i_cfg_idx, i_cfg_data
//   command   in         i_valid / o_ready  i_opcode, i_data_byte, i_divert_mode
//   result    out        o_valid / i_ready  o_popped_byte ... o_push_dropped
//
// The accept edge reads the ring heads; the next edge (exec) updates pointers,
// counts and the result register, and o_valid rises; the result is taken at
// an edge with i_ready high and is held while i_ready is low; o_ready stays low
// until it is taken, so a new word is accepted only after that.
// Synchronous reset clears pointers, fill counts, line count and drain flag
// and restores both codes to their defaults; ring contents are not cleared.
// ----------------------------------------------------------------------------
module serial_ring_buffers_line_count #(
    parameter int RING_DEPTH = srb_pkg::RING_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [srb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [srb_pkg::BYTE_W-1:0]    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [srb_pkg::OP_W-1:0]      i_opcode,
    input  wire logic [srb_pkg::BYTE_W-1:0]    i_data_byte,
    input  wire logic                          i_divert_mode,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [srb_pkg::BYTE_W-1:0]         o_popped_byte,
    output logic                               o_popped_valid,
    output logic                               o_empty_pop,
    output logic [srb_pkg::BYTE_W-1:0]         o_send_byte,
    output logic                               o_send_valid,
    output logic [srb_pkg::BYTE_W-1:0]         o_packet_byte,
    output logic                               o_packet_valid,
    output logic                               o_line_event,
    output logic                               o_bytes_waiting,
    output logic [srb_pkg::BYTE_W-1:0]         o_lines_waiting,
    output logic                               o_transmit_on,
    output logic                               o_push_dropped
);

    srb_pkg::t_cmd cmd;

    srb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    srb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_data_byte     (i_data_byte),
        .i_divert_mode   (i_divert_mode),
        .o_popped_byte   (o_popped_byte),
        .o_popped_valid  (o_popped_valid),
        .o_empty_pop     (o_empty_pop),
        .o_send_byte     (o_send_byte),
        .o_send_valid    (o_send_valid),
        .o_packet_byte   (o_packet_byte),
        .o_packet_valid  (o_packet_valid),
        .o_line_event    (o_line_event),
        .o_bytes_waiting (o_bytes_waiting),
        .o_lines_waiting (o_lines_waiting),
        .o_transmit_on   (o_transmit_on),
        .o_push_dropped  (o_push_dropped)
    );

endmodule
`default_nettype wire
